>>> design/cfae_pkg.sv
// Shared types and constants for the calendar field adjust block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cfae_pkg;

  // command codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_YEAR   = 3'd1,
    CMD_MONTH  = 3'd2,
    CMD_DAY    = 3'd3,
    CMD_HOUR   = 3'd4,
    CMD_MINUTE = 3'd5,
    CMD_SECOND = 3'd6,
    CMD_SET    = 3'd7
  } cfae_cmd_e;

  // controller sequence
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DAYS,
    ST_SECS,
    ST_MULT,
    ST_LOAD
  } cfae_state_e;

  // strobes from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic days;
    logic secs;
    logic mult;
    logic load;
  } cfae_ctrl_t;

  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned SubW    = 8;
  localparam int unsigned SecsW   = 32;
  localparam int unsigned MillisW = 42;

endpackage

>>> design/cfae_ctrl.sv
// Controller state machine for the calendar field adjust block.
// Depends on cfae_pkg; drives the datapath strobes and both handshakes.
`timescale 1ns / 1ps

module cfae_ctrl
  import cfae_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cfae_ctrl_t ctrl_o
);

  cfae_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DAYS;
      ST_DAYS:   state_d = ST_SECS;
      ST_SECS:   state_d = ST_MULT;
      ST_MULT:   state_d = ST_LOAD;
      ST_LOAD:   if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      ST_UPDATE: ctrl_o.update = 1'b1;
      ST_DAYS:   ctrl_o.days   = 1'b1;
      ST_SECS:   ctrl_o.secs   = 1'b1;
      ST_MULT:   ctrl_o.mult   = 1'b1;
      ST_LOAD: begin
        ctrl_o.load = can_load;
        if (can_load) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/cfae_dp.sv
// Datapath for the calendar field adjust block: held calendar, field update,
// day count, epoch seconds and milliseconds. Depends on cfae_pkg.
`timescale 1ns / 1ps

module cfae_dp
  import cfae_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfae_ctrl_t         ctrl_i,
  input  logic [2:0]         cmd_i,
  input  logic [7:0]         direction_i,
  input  logic [YearW-1:0]   new_year_i,
  input  logic [MonthW-1:0]  new_month_i,
  input  logic [DayW-1:0]    new_day_i,
  input  logic [HourW-1:0]   new_hour_i,
  input  logic [MinuteW-1:0] new_minute_i,
  input  logic [SecondW-1:0] new_second_i,
  input  logic [SubW-1:0]    raw_subsecond_i,
  output logic [YearW-1:0]   year_o,
  output logic [MonthW-1:0]  month_o,
  output logic [DayW-1:0]    day_o,
  output logic [HourW-1:0]   hour_o,
  output logic [MinuteW-1:0] minute_o,
  output logic [SecondW-1:0] second_o,
  output logic [WdayW-1:0]   weekday_o,
  output logic [SubW-1:0]    subsecond_o,
  output logic [SecsW-1:0]   unix_seconds_o,
  output logic [MillisW-1:0] unix_millis_o
);

  function automatic logic [4:0] month_len(input logic [6:0] y, input logic [3:0] m);
    logic [4:0] n;
    case (m) inside
      4'd2:                   n = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // out of range above gives the minimum, below gives the maximum
  function automatic logic [6:0] wrap_f(input logic signed [9:0] v,
                                        input logic signed [9:0] lo,
                                        input logic signed [9:0] hi);
    logic [9:0] r;
    if (v > hi)      r = lo;
    else if (v < lo) r = hi;
    else             r = v;
    return r[6:0];
  endfunction

  // captured command beat
  logic [2:0]         cmd_q;
  logic [9:0]         dir_q;
  logic [YearW-1:0]   nyear_q;
  logic [MonthW-1:0]  nmonth_q;
  logic [DayW-1:0]    nday_q;
  logic [HourW-1:0]   nhour_q;
  logic [MinuteW-1:0] nminute_q;
  logic [SecondW-1:0] nsecond_q;
  logic [SubW-1:0]    raw_q;

  // held calendar
  logic [YearW-1:0]   year_q, year_d;
  logic [MonthW-1:0]  month_q, month_d;
  logic [DayW-1:0]    day_q, day_d;
  logic [HourW-1:0]   hour_q, hour_d;
  logic [MinuteW-1:0] minute_q, minute_d;
  logic [SecondW-1:0] second_q, second_d;

  // epoch pipeline
  logic [15:0]        days_q, days_d;
  logic [16:0]        tod_q, tod_d;
  logic [9:0]         frac_q, frac_d;
  logic [SubW-1:0]    sub_q;
  logic [SecsW-1:0]   secs_q, secs_d;
  logic [WdayW-1:0]   wday_q, wday_d;
  logic [MillisW-1:0] millis_q, millis_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q     <= cmd_i;
      dir_q     <= {{2{direction_i[7]}}, direction_i};
      nyear_q   <= new_year_i;
      nmonth_q  <= new_month_i;
      nday_q    <= new_day_i;
      nhour_q   <= new_hour_i;
      nminute_q <= new_minute_i;
      nsecond_q <= new_second_i;
      raw_q     <= raw_subsecond_i;
    end
  end

  always_comb begin
    logic [6:0]  y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  len;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    y = '0;
    m = '0;
    d = '0;
    len = '0;
    unique case (cfae_cmd_e'(cmd_q))
      CMD_YEAR: begin
        y   = wrap_f($signed({3'b000, year_q}) + $signed(dir_q), 10'sd0, 10'sd99);
        len = month_len(y, month_q);
        year_d = y;
        if (day_q > len) begin
          day_d   = day_q - len;
          month_d = month_q + 4'd1;
        end
      end
      CMD_MONTH: begin
        m   = 4'(wrap_f($signed({6'b0, month_q}) + $signed(dir_q), 10'sd1, 10'sd12));
        len = month_len(year_q, m);
        month_d = m;
        if (day_q > len) day_d = len;
      end
      CMD_DAY: begin
        len   = month_len(year_q, month_q);
        day_d = 5'(wrap_f($signed({5'b0, day_q}) + $signed(dir_q), 10'sd1,
                          $signed({5'b0, len})));
      end
      CMD_HOUR:
        hour_d = 5'(wrap_f($signed({5'b0, hour_q}) + $signed(dir_q), 10'sd0, 10'sd23));
      CMD_MINUTE:
        minute_d = 6'(wrap_f($signed({4'b0, minute_q}) + $signed(dir_q), 10'sd0, 10'sd59));
      CMD_SECOND:
        second_d = 6'(wrap_f($signed({4'b0, second_q}) + $signed(dir_q), 10'sd0, 10'sd59));
      CMD_SET: begin
        y = (nyear_q > 7'd99) ? 7'd99 : nyear_q;
        m = (nmonth_q == 4'd0) ? 4'd1 : ((nmonth_q > 4'd12) ? 4'd12 : nmonth_q);
        d = (nday_q == 5'd0) ? 5'd1 : nday_q;
        len = month_len(y, m);
        year_d   = y;
        hour_d   = (nhour_q > 5'd23) ? 5'd23 : nhour_q;
        minute_d = (nminute_q > 6'd59) ? 6'd59 : nminute_q;
        second_d = (nsecond_q > 6'd59) ? 6'd59 : nsecond_q;
        if (d > len) begin
          day_d   = d - len;
          month_d = m + 4'd1;
        end else begin
          day_d   = d;
          month_d = m;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= '0;
      month_q  <= 4'd1;
      day_q    <= 5'd1;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else if (ctrl_i.update) begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
    end
  end

  // day count from 1970-01-01, time of day, millisecond fraction
  always_comb begin
    logic [8:0]      yq4;
    logic [SubW-1:0] sub;
    logic [17:0]     sub_scaled;
    yq4 = {2'b00, year_q} + 9'd3;
    days_d = 16'd10957 + 16'(year_q) * 16'd365 + 16'(yq4[8:2])
           + 16'(days_before(month_q)) + 16'(day_q) - 16'd1;
    if (month_q > 4'd2 && year_q[1:0] == 2'b00) days_d = days_d + 16'd1;
    tod_d = 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);
    // invert at the counter width first so the upper bits stay clear
    sub        = ~raw_q;
    sub_scaled = 18'(sub) * 18'd1000;
    frac_d = sub_scaled[17:8];
  end

  // weekday: octal digit sums keep the value mod 7 since 8 is 1 mod 7
  always_comb begin
    logic [15:0] x;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  r;
    x  = days_q + 16'd3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
       + 6'(x[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    wday_d = 3'(r) + 3'd1;
  end

  always_comb begin
    logic [32:0] prod;
    prod   = 33'(days_q) * 33'd86400 + 33'(tod_q);
    secs_d = prod[SecsW-1:0];
  end

  assign millis_d = MillisW'(secs_q) * MillisW'(1000) + MillisW'(frac_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.days) begin
      days_q <= days_d;
      tod_q  <= tod_d;
      frac_q <= frac_d;
      sub_q  <= ~raw_q;
    end
    if (ctrl_i.secs) begin
      secs_q <= secs_d;
      wday_q <= wday_d;
    end
    if (ctrl_i.mult) millis_q <= millis_d;
    if (ctrl_i.load) begin
      year_o         <= year_q;
      month_o        <= month_q;
      day_o          <= day_q;
      hour_o         <= hour_q;
      minute_o       <= minute_q;
      second_o       <= second_q;
      weekday_o      <= wday_q;
      subsecond_o    <= sub_q;
      unix_seconds_o <= secs_q;
      unix_millis_o  <= millis_q;
    end
  end

endmodule

>>> design/calendar_field_adjust_epoch.sv
// Calendar field adjust block with epoch output: top level.
// Depends on cfae_pkg, cfae_ctrl and cfae_dp.
//
// The block holds a date and time for the years 2000 to 2099 and applies one
// command per input beat: read, set all fields, or add a signed step to one
// field (out of range wraps to the field's minimum or maximum, days follow the
// month length with leap years). Each beat yields one output beat with the
// held fields, the Monday-based weekday, the up-counting sub-second and the
// UTC epoch time in seconds and milliseconds. One beat at a time is in work:
// after acceptance the controller steps through update, day count, seconds
// multiply and millisecond multiply, then loads the output register, and the
// input is ready again only once it is back in idle, so the next beat is
// accepted only after the last one is loaded. A result still waiting in the
// output register does not block the next acceptance; it only holds the load
// step of the following beat until it is taken.
`timescale 1ns / 1ps

module calendar_field_adjust_epoch
  import cfae_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic [7:0]         direction_i,
  input  logic [YearW-1:0]   new_year_i,
  input  logic [MonthW-1:0]  new_month_i,
  input  logic [DayW-1:0]    new_day_i,
  input  logic [HourW-1:0]   new_hour_i,
  input  logic [MinuteW-1:0] new_minute_i,
  input  logic [SecondW-1:0] new_second_i,
  input  logic [SubW-1:0]    raw_subsecond_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [YearW-1:0]   year_o,
  output logic [MonthW-1:0]  month_o,
  output logic [DayW-1:0]    day_o,
  output logic [HourW-1:0]   hour_o,
  output logic [MinuteW-1:0] minute_o,
  output logic [SecondW-1:0] second_o,
  output logic [WdayW-1:0]   weekday_o,
  output logic [SubW-1:0]    subsecond_o,
  output logic [SecsW-1:0]   unix_seconds_o,
  output logic [MillisW-1:0] unix_millis_o
);

  // strobes that step the datapath through one beat
  cfae_ctrl_t ctrl;

  // sequence the beat and own both handshakes
  cfae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // hold the calendar, apply the command, compute the epoch fields
  cfae_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cmd_i           (cmd_i),
    .direction_i     (direction_i),
    .new_year_i      (new_year_i),
    .new_month_i     (new_month_i),
    .new_day_i       (new_day_i),
    .new_hour_i      (new_hour_i),
    .new_minute_i    (new_minute_i),
    .new_second_i    (new_second_i),
    .raw_subsecond_i (raw_subsecond_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o),
    .subsecond_o     (subsecond_o),
    .unix_seconds_o  (unix_seconds_o),
    .unix_millis_o   (unix_millis_o)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking bench for calendar_field_adjust_epoch: random and directed
// command beats, a calendar shadow that predicts every stamp. Needs cfae_pkg.
`timescale 1ns / 1ps

module tb_top;
  import cfae_pkg::*;

  // The slowest legal beat adds a sender idle gap, the busy sequence and a
  // receiver stall, so 1.4k beats stay far below CycleLimit.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBeats = 1400;

  // One command beat as presented on the input channel.
  typedef struct packed {
    cfae_cmd_e           cmd;
    logic signed [7:0]   direction;
    logic [YearW-1:0]    new_year;
    logic [MonthW-1:0]   new_month;
    logic [DayW-1:0]     new_day;
    logic [HourW-1:0]    new_hour;
    logic [MinuteW-1:0]  new_minute;
    logic [SecondW-1:0]  new_second;
    logic [SubW-1:0]     raw_subsecond;
  } command_beat_t;

  // One time stamp as returned on the output channel.
  typedef struct packed {
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [SecondW-1:0]  second;
    logic [WdayW-1:0]    weekday;
    logic [SubW-1:0]     subsecond;
    logic [SecsW-1:0]    unix_seconds;
    logic [MillisW-1:0]  unix_millis;
  } stamp_t;

  // Shadow copy of the held calendar plus the stamps still owed by the block.
  class calendar_shadow;
    int     year, month, day, hour, minute, second;
    stamp_t due_stamps[$];
    int     mismatches;

    function new();
      year       = 0;
      month      = 1;
      day        = 1;
      hour       = 0;
      minute     = 0;
      second     = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_stamps.size();
    endfunction

    function int month_len(int y, int m);
      case (m)
        2:             return (y % 4 == 0) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    function int days_before(int m);
      case (m)
        1:       return 0;
        2:       return 31;
        3:       return 59;
        4:       return 90;
        5:       return 120;
        6:       return 151;
        7:       return 181;
        8:       return 212;
        9:       return 243;
        10:      return 273;
        11:      return 304;
        default: return 334;
      endcase
    endfunction

    // Out of range goes to the opposite end, never modulo.
    function int wrap(int v, int lo, int hi);
      if (v > hi) return lo;
      if (v < lo) return hi;
      return v;
    endfunction

    // A day past month end spills into the next month (never past December).
    function void spill_day();
      int len;
      len = month_len(year, month);
      if (day > len) begin
        day   = day - len;
        month = month + 1;
      end
    endfunction

    // Apply one accepted command and queue the stamp it must produce.
    function void apply_command(command_beat_t b);
      int              dir, len, days, frac;
      longint unsigned secs, millis;
      stamp_t          s;
      dir = int'(b.direction);
      case (b.cmd)
        CMD_YEAR: begin
          year = wrap(year + dir, 0, 99);
          spill_day();
        end
        CMD_MONTH: begin
          month = wrap(month + dir, 1, 12);
          len   = month_len(year, month);
          if (day > len) day = len;
        end
        CMD_DAY:    day    = wrap(day + dir, 1, month_len(year, month));
        CMD_HOUR:   hour   = wrap(hour + dir, 0, 23);
        CMD_MINUTE: minute = wrap(minute + dir, 0, 59);
        CMD_SECOND: second = wrap(second + dir, 0, 59);
        CMD_SET: begin
          year   = (int'(b.new_year) > 99) ? 99 : int'(b.new_year);
          month  = (int'(b.new_month) > 12) ? 12 : int'(b.new_month);
          if (month == 0) month = 1;
          day    = (int'(b.new_day) == 0) ? 1 : int'(b.new_day);
          hour   = (int'(b.new_hour) > 23) ? 23 : int'(b.new_hour);
          minute = (int'(b.new_minute) > 59) ? 59 : int'(b.new_minute);
          second = (int'(b.new_second) > 59) ? 59 : int'(b.new_second);
          spill_day();
        end
        default: ;
      endcase

      // 10957 days separate 1970-01-01 from 2000-01-01
      days = 10957 + 365 * year + (year + 3) / 4 + days_before(month) + day - 1;
      if (month > 2 && year % 4 == 0) days = days + 1;
      frac   = 255 - int'(b.raw_subsecond);
      secs   = longint'(days) * 86400 + longint'(hour) * 3600
             + longint'(minute) * 60 + longint'(second);
      millis = secs * 1000 + longint'(frac * 1000 / 256);

      s.year         = YearW'(year);
      s.month        = MonthW'(month);
      s.day          = DayW'(day);
      s.hour         = HourW'(hour);
      s.minute       = MinuteW'(minute);
      s.second       = SecondW'(second);
      s.weekday      = WdayW'((days + 3) % 7 + 1);   // Thursday epoch
      s.subsecond    = SubW'(frac);
      s.unix_seconds = SecsW'(secs);
      s.unix_millis  = MillisW'(millis);
      due_stamps.push_back(s);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Match one received stamp against the oldest one owed.
    function void check_stamp(stamp_t got);
      stamp_t want;
      if (due_stamps.size() == 0) begin
        $error("stamp beat arrived with no command waiting for it");
        mismatches++;
        return;
      end
      want = due_stamps.pop_front();
      compare_field("year",         64'(want.year),         64'(got.year));
      compare_field("month",        64'(want.month),        64'(got.month));
      compare_field("day",          64'(want.day),          64'(got.day));
      compare_field("hour",         64'(want.hour),         64'(got.hour));
      compare_field("minute",       64'(want.minute),       64'(got.minute));
      compare_field("second",       64'(want.second),       64'(got.second));
      compare_field("weekday",      64'(want.weekday),      64'(got.weekday));
      compare_field("subsecond",    64'(want.subsecond),    64'(got.subsecond));
      compare_field("unix_seconds", 64'(want.unix_seconds), 64'(got.unix_seconds));
      compare_field("unix_millis",  64'(want.unix_millis),  64'(got.unix_millis));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         cmd_i;
  logic [7:0]         direction_i;
  logic [YearW-1:0]   new_year_i;
  logic [MonthW-1:0]  new_month_i;
  logic [DayW-1:0]    new_day_i;
  logic [HourW-1:0]   new_hour_i;
  logic [MinuteW-1:0] new_minute_i;
  logic [SecondW-1:0] new_second_i;
  logic [SubW-1:0]    raw_subsecond_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [YearW-1:0]   year_o;
  logic [MonthW-1:0]  month_o;
  logic [DayW-1:0]    day_o;
  logic [HourW-1:0]   hour_o;
  logic [MinuteW-1:0] minute_o;
  logic [SecondW-1:0] second_o;
  logic [WdayW-1:0]   weekday_o;
  logic [SubW-1:0]    subsecond_o;
  logic [SecsW-1:0]   unix_seconds_o;
  logic [MillisW-1:0] unix_millis_o;

  calendar_shadow shadow;
  bit             no_idle = 1'b0;   // burst stretch: both sides skip their gaps
  int unsigned    cycles  = 0;

  calendar_field_adjust_epoch dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .direction_i     (direction_i),
    .new_year_i      (new_year_i),
    .new_month_i     (new_month_i),
    .new_day_i       (new_day_i),
    .new_hour_i      (new_hour_i),
    .new_minute_i    (new_minute_i),
    .new_second_i    (new_second_i),
    .raw_subsecond_i (raw_subsecond_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o),
    .subsecond_o     (subsecond_o),
    .unix_seconds_o  (unix_seconds_o),
    .unix_millis_o   (unix_millis_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: kill a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic command_beat_t mk(cfae_cmd_e c, int dir, int y, int m, int d,
                                       int h, int mi, int s, int raw);
    command_beat_t b;
    b.cmd           = c;
    b.direction     = 8'(dir);
    b.new_year      = YearW'(y);
    b.new_month     = MonthW'(m);
    b.new_day       = DayW'(d);
    b.new_hour      = HourW'(h);
    b.new_minute    = MinuteW'(mi);
    b.new_second    = SecondW'(s);
    b.raw_subsecond = SubW'(raw);
    return b;
  endfunction

  // Mostly field steps and well-formed sets; a slice of raw-bit sets as noise.
  function automatic command_beat_t random_beat();
    command_beat_t b;
    int            pick, dpick;
    b = mk(CMD_READ, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
           int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    pick = int'($urandom_range(0, 99));
    if (pick < 8) begin
      b.cmd = CMD_READ;
    end else if (pick < 22) begin
      // in-range set; days up to 31 exercise the month-end spill
      b.cmd        = CMD_SET;
      b.new_year   = YearW'($urandom_range(0, 99));
      b.new_month  = MonthW'($urandom_range(1, 12));
      b.new_day    = DayW'($urandom_range(1, 31));
      b.new_hour   = HourW'($urandom_range(0, 23));
      b.new_minute = MinuteW'($urandom_range(0, 59));
      b.new_second = SecondW'($urandom_range(0, 59));
    end else if (pick < 27) begin
      b.cmd = CMD_SET;   // raw bits: saturation paths
    end else begin
      b.cmd = cfae_cmd_e'($urandom_range(1, 6));
      dpick = int'($urandom_range(0, 99));
      if (dpick < 60)
        b.direction = 8'(int'($urandom_range(0, 6)) - 3);
      else if (dpick < 85)
        b.direction = 8'(int'($urandom_range(0, 120)) - 60);
    end
    return b;
  endfunction

  // Present one command beat and hold it until the block takes it.
  // Entered and left at a falling edge.
  task automatic send_beat(command_beat_t b);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i           <= b.cmd;
    direction_i     <= b.direction;
    new_year_i      <= b.new_year;
    new_month_i     <= b.new_month;
    new_day_i       <= b.new_day;
    new_hour_i      <= b.new_hour;
    new_minute_i    <= b.new_minute;
    new_second_i    <= b.new_second;
    raw_subsecond_i <= b.raw_subsecond;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.apply_command(b);
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed corners, then the random stream.
  initial begin
    shadow          = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_READ;
    direction_i     = '0;
    new_year_i      = '0;
    new_month_i     = '0;
    new_day_i       = '0;
    new_hour_i      = '0;
    new_minute_i    = '0;
    new_second_i    = '0;
    raw_subsecond_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // read the reset value at both sub-second extremes
    send_beat(mk(CMD_READ, 127, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(CMD_READ, -128, 127, 15, 31, 31, 63, 63, 255));
    // set with all-zero fields, then all-ones fields (clamp to 2099-12-31 23:59:59)
    send_beat(mk(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 8'h55));
    send_beat(mk(CMD_SET, -1, 127, 15, 31, 31, 63, 63, 8'hAA));
    // every field past its top wraps to its minimum
    send_beat(mk(CMD_SECOND, 1, 0, 0, 0, 0, 0, 0, 3));
    send_beat(mk(CMD_MINUTE, 1, 0, 0, 0, 0, 0, 0, 4));
    send_beat(mk(CMD_HOUR, 1, 0, 0, 0, 0, 0, 0, 5));
    send_beat(mk(CMD_DAY, 1, 0, 0, 0, 0, 0, 0, 6));
    send_beat(mk(CMD_MONTH, 1, 0, 0, 0, 0, 0, 0, 7));
    send_beat(mk(CMD_YEAR, 1, 0, 0, 0, 0, 0, 0, 8));
    // below the bottom: year 2000 minus one goes to 2099
    send_beat(mk(CMD_YEAR, -1, 0, 0, 0, 0, 0, 0, 9));
    // leap day, then a year step into a common year spills to 1 March
    send_beat(mk(CMD_SET, 0, 0, 2, 29, 12, 30, 45, 200));
    send_beat(mk(CMD_YEAR, 1, 0, 0, 0, 0, 0, 0, 201));
    // set past month end: 31 February in a common year, 31 April in a leap year
    send_beat(mk(CMD_SET, 0, 1, 2, 31, 1, 2, 3, 17));
    send_beat(mk(CMD_SET, 0, 4, 4, 31, 4, 5, 6, 18));
    // month step clamps 31 January to 29 February
    send_beat(mk(CMD_SET, 0, 4, 1, 31, 7, 8, 9, 19));
    send_beat(mk(CMD_MONTH, 1, 0, 0, 0, 0, 0, 0, 20));
    // far-out steps in both directions
    send_beat(mk(CMD_DAY, -128, 0, 0, 0, 0, 0, 0, 21));
    send_beat(mk(CMD_HOUR, 127, 0, 0, 0, 0, 0, 0, 22));
    send_beat(mk(CMD_MINUTE, -128, 0, 0, 0, 0, 0, 0, 23));
    send_beat(mk(CMD_SECOND, -1, 0, 0, 0, 0, 0, 0, 24));
    send_beat(mk(CMD_MONTH, -5, 0, 0, 0, 0, 0, 0, 25));
    // day past the year's last day wraps to the 1st
    send_beat(mk(CMD_SET, 0, 1, 12, 31, 23, 59, 59, 0));
    send_beat(mk(CMD_DAY, 1, 0, 0, 0, 0, 0, 0, 255));

    for (int i = 0; i < RandomBeats; i++) begin
      // re-draw the idling mode now and then so bursts show up
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_beat(random_beat());
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    // drain: all owed stamps, then a few extra cycles for stray beats
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Receiver: stall at random, take each stamp beat and check it.
  initial begin
    stamp_t got;
    int     gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = no_idle ? 0 : int'($urandom_range(0, 10));
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.year         = year_o;
      got.month        = month_o;
      got.day          = day_o;
      got.hour         = hour_o;
      got.minute       = minute_o;
      got.second       = second_o;
      got.weekday      = weekday_o;
      got.subsecond    = subsecond_o;
      got.unix_seconds = unix_seconds_o;
      got.unix_millis  = unix_millis_o;
      shadow.check_stamp(got);
      @(negedge clk_i);
    end
  end

endmodule
